// ===== sv/hcor_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hcor_pkg
// shared types and codes for the handle cache with oldest-entry replacement
// ============================================================================
package hcor_pkg;

    localparam int ACT_W       = 3;
    localparam int KEY_W       = 64;
    localparam int HIN_W       = 32;
    localparam int OUT_H_W     = 32;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;

    // action codes, codes 5 to 7 are treated as no-op
    localparam logic [ACT_W-1:0] ACT_TAKE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_STORE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DROP    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

    // which kind of result the datapath builds on a load
    typedef enum logic [1:0] {
        RES_OP,
        RES_EVICT,
        RES_CLR
    } res_sel_t;

    typedef struct packed {
        logic     latch;
        logic     load;
        res_sel_t sel;
        logic     scan_start;
        logic     scan_step;
        logic     clr_start;
    } hcor_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             key_zero;
        logic             free_any;
        logic             scan_last;
        logic             clr_last;
        logic             out_free;
    } hcor_status_t;

endpackage

// ===== sv/hcor_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hcor_ctrl
// sequencer for the handle cache: accept, execute, victim scan, clear-all
// ============================================================================
module hcor_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hcor_pkg::hcor_status_t status,
    output hcor_pkg::hcor_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EVICT,
        ST_CLR
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.sel        = hcor_pkg::RES_OP;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.action == hcor_pkg::ACT_CLEAR) begin
                    cmd.clr_start = 1'b1;
                    state_next    = ST_CLR;
                end else if (status.action == hcor_pkg::ACT_STORE && !status.key_zero
                             && !status.free_any) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                cmd.sel = hcor_pkg::RES_EVICT;
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR: begin
                cmd.sel = hcor_pkg::RES_CLR;
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (status.clr_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/hcor_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hcor_datapath
// slot storage, key match, free-slot search, age scan and result register
// ============================================================================
module hcor_datapath #(
    parameter int ENTRIES     = 4,
    parameter int HANDLE_BITS = 32,
    parameter int AGE_BITS    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hcor_pkg::hcor_cmd_t                 cmd,
    output hcor_pkg::hcor_status_t              status,
    input  logic [hcor_pkg::ACT_W-1:0]          in_action,
    input  logic [hcor_pkg::KEY_W-1:0]          in_key,
    input  logic [hcor_pkg::HIN_W-1:0]          in_handle,
    output logic                                o_valid,
    input  logic                                o_ready,
    output logic                                o_found,
    output logic [hcor_pkg::OUT_H_W-1:0]        o_handle_out,
    output logic                                o_closed,
    output logic [hcor_pkg::OUT_H_W-1:0]        o_closed_handle,
    output logic                                o_last
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    function automatic logic [hcor_pkg::OUT_H_W-1:0] to_out(input logic [HANDLE_BITS-1:0] h);
        logic [63:0] ext;
        ext = 64'(h);
        return ext[hcor_pkg::OUT_H_W-1:0];
    endfunction

    // latched request
    logic [hcor_pkg::ACT_W-1:0] act_reg;
    logic [hcor_pkg::KEY_W-1:0] key_reg;
    logic [HANDLE_BITS-1:0]     hin_reg;

    // slots
    logic [ENTRIES-1:0]         slot_valid_reg, slot_valid_next;
    logic [hcor_pkg::KEY_W-1:0] slot_key_reg    [ENTRIES];
    logic [HANDLE_BITS-1:0]     slot_handle_reg [ENTRIES];
    logic [AGE_BITS-1:0]        slot_age_reg    [ENTRIES];
    logic [AGE_BITS-1:0]        next_age_reg;

    // victim scan and clear-all bookkeeping
    logic [IDX_W-1:0]           scan_idx_reg;
    logic [IDX_W-1:0]           cand_reg;
    logic [AGE_BITS-1:0]        cand_age_reg;
    logic [ENTRIES-1:0]         pend_reg;

    logic                       out_valid_reg;
    logic                       out_found_reg, out_last_reg;
    logic [HANDLE_BITS-1:0]     out_hout_reg, out_chandle_reg;

    logic [ENTRIES-1:0] match, nonnull, ref_free, hit_oh, pend_low_oh, pend_rest;
    logic               key_zero, hit, free_any;
    logic [IDX_W-1:0]   hit_idx, free_idx, ref_idx, pend_idx, rd_idx;
    logic [HANDLE_BITS-1:0] rd_handle, hin_keep;
    logic [AGE_BITS-1:0]    scan_age;
    logic                   out_free;

    logic                   r_found, r_last;
    logic [HANDLE_BITS-1:0] r_hout, r_chandle, put_handle;
    logic                   put_en, clr_en;
    logic [IDX_W-1:0]       put_idx;

    assign hin_keep = HANDLE_BITS'(64'(in_handle));
    assign key_zero = (key_reg == '0);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]   = slot_valid_reg[i] && (slot_key_reg[i] == key_reg);
            nonnull[i] = (slot_handle_reg[i] != '0);
        end
    end

    assign hit    = !key_zero && (match != '0);
    assign hit_oh = ENTRIES'(1) << hit_idx;
    assign ref_free = ~(slot_valid_reg & ~hit_oh);
    assign free_any = (slot_valid_reg != {ENTRIES{1'b1}});
    assign pend_low_oh = pend_reg & (~pend_reg + ENTRIES'(1));
    assign pend_rest   = pend_reg & ~pend_low_oh;

    // lowest-index priority encoders
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        ref_idx  = '0;
        pend_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i])           hit_idx  = IDX_W'(i);
            if (!slot_valid_reg[i]) free_idx = IDX_W'(i);
            if (ref_free[i])        ref_idx  = IDX_W'(i);
            if (pend_reg[i])        pend_idx = IDX_W'(i);
        end
    end

    // single handle read port
    always_comb begin
        case (cmd.sel)
            hcor_pkg::RES_EVICT: rd_idx = cand_reg;
            hcor_pkg::RES_CLR:   rd_idx = pend_idx;
            default:             rd_idx = hit_idx;
        endcase
    end
    assign rd_handle = slot_handle_reg[rd_idx];
    assign scan_age  = slot_age_reg[scan_idx_reg];

    // result and slot write selection
    always_comb begin
        r_found    = 1'b0;
        r_hout     = '0;
        r_chandle  = '0;
        r_last     = 1'b1;
        put_en     = 1'b0;
        put_idx    = free_idx;
        put_handle = hin_reg;
        clr_en     = 1'b0;
        case (cmd.sel)
            hcor_pkg::RES_EVICT: begin
                r_chandle = rd_handle;
                put_en    = 1'b1;
                put_idx   = cand_reg;
            end
            hcor_pkg::RES_CLR: begin
                if (pend_reg != '0) begin
                    r_chandle = rd_handle;
                end
                r_last = (pend_rest == '0);
            end
            default: begin
                case (act_reg)
                    hcor_pkg::ACT_TAKE: begin
                        if (hit) begin
                            r_found = 1'b1;
                            r_hout  = rd_handle;
                            clr_en  = 1'b1;
                        end
                    end
                    hcor_pkg::ACT_STORE: begin
                        if (key_zero) begin
                            r_chandle = hin_reg;
                        end else begin
                            put_en = 1'b1;
                        end
                    end
                    hcor_pkg::ACT_DROP: begin
                        if (hit) begin
                            r_found   = 1'b1;
                            r_chandle = rd_handle;
                            clr_en    = 1'b1;
                        end
                    end
                    hcor_pkg::ACT_REFRESH: begin
                        if (hit) begin
                            r_found    = 1'b1;
                            r_hout     = rd_handle;
                            clr_en     = 1'b1;
                            put_en     = 1'b1;
                            put_idx    = ref_idx;
                            put_handle = rd_handle;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        slot_valid_next = slot_valid_reg;
        if (cmd.clr_start) begin
            slot_valid_next = '0;
        end
        if (cmd.load) begin
            if (clr_en) slot_valid_next[hit_idx] = 1'b0;
            if (put_en) slot_valid_next[put_idx] = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            next_age_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            slot_valid_reg <= slot_valid_next;
            if (cmd.load && put_en) begin
                next_age_reg <= next_age_reg + AGE_BITS'(1);
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (o_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            act_reg <= in_action;
            key_reg <= in_key;
            hin_reg <= hin_keep;
        end
        if (cmd.load && put_en) begin
            slot_key_reg[put_idx]    <= key_reg;
            slot_handle_reg[put_idx] <= put_handle;
            slot_age_reg[put_idx]    <= next_age_reg;
        end
        if (cmd.scan_start) begin
            cand_reg     <= '0;
            cand_age_reg <= slot_age_reg[0];
            scan_idx_reg <= IDX_W'(1);
        end else if (cmd.scan_step) begin
            if (scan_age < cand_age_reg) begin
                cand_reg     <= scan_idx_reg;
                cand_age_reg <= scan_age;
            end
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (cmd.clr_start) begin
            pend_reg <= slot_valid_reg & nonnull;
        end else if (cmd.load && cmd.sel == hcor_pkg::RES_CLR) begin
            pend_reg <= pend_rest;
        end
        if (cmd.load) begin
            out_found_reg   <= r_found;
            out_hout_reg    <= r_hout;
            out_chandle_reg <= r_chandle;
            out_last_reg    <= r_last;
        end
    end

    assign status.action    = act_reg;
    assign status.key_zero  = key_zero;
    assign status.free_any  = free_any;
    assign status.scan_last = (scan_idx_reg == IDX_W'(ENTRIES - 1));
    assign status.clr_last  = (pend_rest == '0);
    assign status.out_free  = out_free;

    assign o_valid         = out_valid_reg;
    assign o_found         = out_found_reg;
    assign o_handle_out    = to_out(out_hout_reg);
    assign o_closed        = (to_out(out_chandle_reg) != '0);
    assign o_closed_handle = to_out(out_chandle_reg);
    assign o_last          = out_last_reg;

endmodule

// ===== sv/handle_cache_oldest_replace.sv =====
`timescale 1ns / 1ps
// ============================================================================
// handle_cache_oldest_replace
// fully associative key-to-handle cache with oldest-insertion replacement
// ============================================================================
// usage
//   s_axis carries one request beat: action, 64-bit key and handle.
//   m_axis returns result beats; m_axis_tlast marks the final beat of a
//   request. every action gives one beat, except clear-all which gives one
//   beat per valid slot with a non-null handle (or a single empty beat).
// sequencing
//   a request is taken in one cycle and executed in the next; the result
//   beat is registered, and a new request is taken only back in idle.
//   a store into a full table first runs the age scan, which compares one
//   slot per cycle to find the oldest entry. clear-all gives its result
//   beats one after another.
// reset
//   aresetn (synchronous, active low) invalidates every slot and zeroes the
//   age counter; slot contents are not cleared.
// stalls
//   results go through a single output register; while m_axis_tready is low
//   the block holds its beat and finishes no further request.
// ============================================================================
module handle_cache_oldest_replace #(
    parameter int ENTRIES     = 4,
    parameter int HANDLE_BITS = 32,
    parameter int AGE_BITS    = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // action[2:0], key[66:3], handle_in[98:67], zero fill
    input  logic [hcor_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // found[0], handle_out[32:1], closed[33], closed_handle[65:34], zero fill
    output logic [hcor_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast
);

    hcor_pkg::hcor_cmd_t    cmd;
    hcor_pkg::hcor_status_t status;

    logic                          found, closed;
    logic [hcor_pkg::OUT_H_W-1:0]  handle_out, closed_handle;

    // sequencer
    hcor_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // slots, lookup, age scan and result register
    hcor_datapath #(
        .ENTRIES     (ENTRIES),
        .HANDLE_BITS (HANDLE_BITS),
        .AGE_BITS    (AGE_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_action       (s_axis_tdata[2:0]),
        .in_key          (s_axis_tdata[66:3]),
        .in_handle       (s_axis_tdata[98:67]),
        .o_valid         (m_axis_tvalid),
        .o_ready         (m_axis_tready),
        .o_found         (found),
        .o_handle_out    (handle_out),
        .o_closed        (closed),
        .o_closed_handle (closed_handle),
        .o_last          (m_axis_tlast)
    );

    // result beat packing
    assign m_axis_tdata = {6'b0, closed_handle, closed, handle_out, found};

endmodule

// ===== sv/hcor_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hcor_checker
// port-level checks for the handle cache, bound to the top level
// ============================================================================
module hcor_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [hcor_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [hcor_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed under stall");

    // one request at a time: no accept right after an accept
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one executes");

    // closed flag agrees with the closed handle
    a_closed_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[33] == (m_axis_tdata[65:34] != 32'd0)))
        else $error("closed flag disagrees with closed handle");

    // a hit result is always the only beat of its request
    a_found_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tlast)
        else $error("hit result not marked last");

    // non-final beats only come from clear-all and always close a handle
    a_mid_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[33] && !m_axis_tdata[0])
        else $error("non-final beat without a closed handle");

endmodule

bind handle_cache_oldest_replace hcor_checker u_hcor_checker (.*);
